[hw/rtl/dnpfc_pkg.sv]
// Shared types, constants and the CRC byte update for the DNP3 link frame checker.
package dnpfc_pkg;

  localparam int unsigned COUNT_BITS = 16;

  localparam logic [7:0]  SYNC_LOW   = 8'h05;
  localparam logic [7:0]  SYNC_HIGH  = 8'h64;
  localparam logic [15:0] CRC_POLY   = 16'hA6BC;
  localparam logic [8:0]  HEADER_LEN = 9'd10;
  localparam logic [4:0]  BLOCK_DATA = 5'd16;
  localparam logic [8:0]  BLOCK_FULL = 9'd18;
  localparam logic [8:0]  MIN_LEN    = 9'd5;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef enum logic [2:0] {
    VerdictNeedMore = 3'd0,
    VerdictUnframed = 3'd1,
    VerdictFalseStart = 3'd2,
    VerdictGood = 3'd3,
    VerdictCorrupt = 3'd4
  } verdict_e;

  typedef enum logic [3:0] {
    PhHunt   = 4'b0001,
    PhHeader = 4'b0010,
    PhBody   = 4'b0100,
    PhDone   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic        valid;
    verdict_e    verdict;
    logic [15:0] count;
  } result_t;

  // Reflected CRC-16, one byte, bitwise.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC after the two sync bytes, seeded with zero.
  localparam logic [15:0] CRC_SYNC = crc_byte(crc_byte(16'h0000, SYNC_LOW), SYNC_HIGH);

  // Bytes in the block starting at 'start' (data plus its two CRC bytes).
  function automatic logic [4:0] block_len(logic [8:0] flen, logic [8:0] start);
    logic [8:0] rem;
    logic [4:0] n;
    rem = (flen >= start) ? (flen - start) : 9'd0;
    if (rem >= BLOCK_FULL) begin
      n = BLOCK_DATA;
    end else if (rem >= 9'd2) begin
      n = 5'(rem - 9'd2);
    end else begin
      n = 5'd0;
    end
    return n + 5'd2;
  endfunction

endpackage

[hw/rtl/dnpfc_scan.sv]
// Per-byte frame scanner: sync hunt, header CRC, block CRCs and the verdict.
module dnpfc_scan import dnpfc_pkg::*; #(
  parameter int unsigned CountBits = COUNT_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output result_t    res_o
);

  localparam int unsigned ExtW = (CountBits > 16) ? CountBits : 16;

  phase_e               phase_q, phase_d;
  logic [CountBits-1:0] pos_q, pos_d;
  logic                 prior_q, prior_d;
  logic [15:0]          crc_q, crc_d;
  logic [8:0]           flen_q, flen_d;
  logic [4:0]           bleft_q, bleft_d;
  logic [8:0]           bstart_q, bstart_d;
  logic [8:0]           boff_q, boff_d;
  logic                 bad_q, bad_d;

  logic [CountBits-1:0] pos_nx;
  logic [15:0]          crc_upd;
  logic                 fin;
  verdict_e             fin_verdict;
  logic [CountBits-1:0] fin_cnt;
  logic [ExtW-1:0]      cnt_ext;
  logic [8:0]           tot;
  logic [7:0]           user;
  logic [7:0]           want;
  logic [4:0]           bleft_n;
  logic                 bad_h;

  assign pos_nx  = (pos_q == '1) ? pos_q : pos_q + CountBits'(1);
  assign crc_upd = crc_byte(crc_q, byte_i);
  assign user    = 8'(flen_q - MIN_LEN);
  assign tot     = flen_q + MIN_LEN + {3'b000, user[7:4], 1'b0}
                   + ((|user[3:0]) ? 9'd2 : 9'd0);
  assign cnt_ext = ExtW'(fin_cnt);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    prior_d     = prior_q;
    crc_d       = crc_q;
    flen_d      = flen_q;
    bleft_d     = bleft_q;
    bstart_d    = bstart_q;
    boff_d      = boff_q;
    bad_d       = bad_q;
    fin         = 1'b0;
    fin_verdict = VerdictNeedMore;
    fin_cnt     = '0;
    want        = 8'h00;
    bleft_n     = 5'd0;
    bad_h       = 1'b0;
    res_o       = '0;

    if (fire_i && phase_q != PhDone) begin
      pos_d = pos_nx;
      case (phase_q)
        PhHunt: begin
          if (prior_q && byte_i == SYNC_HIGH) begin
            if (pos_q != CountBits'(1)) begin
              fin         = 1'b1;
              fin_verdict = VerdictUnframed;
              fin_cnt     = pos_q - CountBits'(1);
            end else begin
              phase_d = PhHeader;
              prior_d = 1'b0;
              crc_d   = CRC_SYNC;
            end
          end else begin
            prior_d = (byte_i == SYNC_LOW);
            if (last_i) begin
              fin         = 1'b1;
              fin_cnt     = pos_nx - CountBits'(byte_i == SYNC_LOW);
              fin_verdict = (fin_cnt != '0) ? VerdictUnframed : VerdictNeedMore;
            end
          end
        end
        PhHeader: begin
          if (pos_q == CountBits'(2)) begin
            flen_d = {1'b0, byte_i};
          end
          if (pos_q < CountBits'(8)) begin
            crc_d = (pos_q == CountBits'(7)) ? ~crc_upd : crc_upd;
          end else if (pos_q == CountBits'(8)) begin
            if (byte_i != crc_q[7:0]) begin
              bad_d = 1'b1;
            end
          end else begin
            bad_h = bad_q || (byte_i != crc_q[15:8]);
            bad_d = bad_h;
            if (bad_h || flen_q < MIN_LEN) begin
              fin         = 1'b1;
              fin_verdict = VerdictFalseStart;
              fin_cnt     = CountBits'(2);
            end else if (tot == HEADER_LEN) begin
              fin         = 1'b1;
              fin_verdict = VerdictGood;
              fin_cnt     = CountBits'(HEADER_LEN);
            end else begin
              flen_d   = tot;
              bad_d    = 1'b0;
              boff_d   = 9'd0;
              phase_d  = PhBody;
              bstart_d = HEADER_LEN;
              bleft_d  = block_len(tot, HEADER_LEN);
              crc_d    = 16'h0000;
            end
          end
        end
        PhBody: begin
          if (bleft_q > 5'd2) begin
            crc_d = (bleft_q == 5'd3) ? ~crc_upd : crc_upd;
          end else begin
            want = (bleft_q == 5'd2) ? crc_q[7:0] : crc_q[15:8];
            if (byte_i != want && !bad_q) begin
              bad_d  = 1'b1;
              boff_d = bstart_q;
            end
          end
          bleft_n = (bleft_q != 5'd0) ? bleft_q - 5'd1 : 5'd0;
          bleft_d = bleft_n;
          if (pos_nx >= CountBits'(flen_q)) begin
            fin         = 1'b1;
            fin_verdict = bad_d ? VerdictCorrupt : VerdictGood;
            fin_cnt     = bad_d ? CountBits'(boff_d) : CountBits'(flen_q);
          end else if (bleft_n == 5'd0) begin
            bstart_d = pos_nx[8:0];
            bleft_d  = block_len(flen_q, pos_nx[8:0]);
            crc_d    = 16'h0000;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase

      if (fin) begin
        res_o.valid   = 1'b1;
        res_o.verdict = fin_verdict;
        res_o.count   = (cnt_ext > ExtW'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[15:0];
        if (!last_i) begin
          phase_d = PhDone;
        end
      end else if (last_i) begin
        res_o.valid   = 1'b1;
        res_o.verdict = VerdictNeedMore;
        res_o.count   = 16'h0000;
      end
    end

    // Marked last byte always starts a fresh pass.
    if (fire_i && last_i) begin
      phase_d  = PhHunt;
      pos_d    = '0;
      prior_d  = 1'b0;
      crc_d    = 16'h0000;
      flen_d   = 9'd0;
      bleft_d  = 5'd0;
      bstart_d = 9'd0;
      boff_d   = 9'd0;
      bad_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      pos_q    <= '0;
      prior_q  <= 1'b0;
      crc_q    <= 16'h0000;
      flen_q   <= 9'd0;
      bleft_q  <= 5'd0;
      bstart_q <= 9'd0;
      boff_q   <= 9'd0;
      bad_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      prior_q  <= prior_d;
      crc_q    <= crc_d;
      flen_q   <= flen_d;
      bleft_q  <= bleft_d;
      bstart_q <= bstart_d;
      boff_q   <= boff_d;
      bad_q    <= bad_d;
    end
  end

  a_res_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> fire_i)
    else $error("verdict without a byte");

  a_body_block_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhBody) |-> (bleft_q >= 5'd1 && bleft_q <= 5'd18))
    else $error("block byte count out of range");

  a_decided_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.valid && !last_i) |=> (phase_q == PhDone))
    else $error("pass not held after verdict");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone) |-> !res_o.valid)
    else $error("second verdict in one pass");

endmodule

[hw/rtl/dnpfc_out_reg.sv]
// Result register holding one verdict until the consumer takes it.
module dnpfc_out_reg import dnpfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  result_t     res_i,
  input  logic        out_stall_i,
  output logic        advance_o,
  output logic        out_valid_o,
  output logic [2:0]  verdict_o,
  output logic [15:0] count_o
);

  logic        vld_q, vld_d;
  verdict_e    verdict_q;
  logic [15:0] count_q;

  assign advance_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (advance_o) begin
      vld_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.valid) begin
      verdict_q <= res_i.verdict;
      count_q   <= res_i.count;
    end
  end

  assign out_valid_o = vld_q;
  assign verdict_o   = verdict_q;
  assign count_o     = count_q;

endmodule

[hw/rtl/dnp3_link_frame_checker_core.sv]
// DNP3 link frame checker: input register, byte scanner and result register.
// A verdict is decided by the scanner from the input register and held in the result register.
// Throughput: one byte per cycle while the input is not stalled; the scanner does one CRC byte update per cycle.
// Input stalls only while a finished verdict waits in the result register and the
// consumer stalls it.
// Reset (rst_ni, async, active low) empties both registers and starts a new pass.
module dnp3_link_frame_checker_core import dnpfc_pkg::*; #(
  parameter int unsigned CountBits = COUNT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        buffer_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  verdict_o,
  output logic [15:0] consume_count_o
);

  // Input register: one request (byte plus last-byte mark) waiting for the scanner.
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       last_q;

  logic       advance;  // result register can take a new verdict
  logic       fire;     // scanner consumes the held request this cycle
  logic       in_take;
  result_t    res;

  assign fire       = in_vld_q && advance;
  // The held request only waits when the result register is full and stalled.
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Payload needs no reset; it is only looked at under in_vld_q.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      last_q <= buffer_last_i;
    end
  end

  // Scanner: all per-byte work, one pass state, at most one verdict per byte.
  dnpfc_scan #(
    .CountBits (CountBits)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .last_i (last_q),
    .res_o  (res)
  );

  // Result register decouples the consumer's stall from the scanner.
  dnpfc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .verdict_o   (verdict_o),
    .count_o     (consume_count_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_vld_q))
    else $error("input stalled without a blocked verdict");

  a_request_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> in_vld_q)
    else $error("held request dropped");

  a_verdict_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(verdict_o) && $stable(consume_count_o)))
    else $error("stalled verdict changed");

endmodule

[tb/dnp3_link_frame_checker_core_tb.sv]
// Self-checking testbench for the DNP3 link frame checker core.
module dnp3_link_frame_checker_core_tb;
  import dnpfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned POS_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam int MAX_GAP = 60;       // longest idle run either side may insert
  localparam int HOLD_CYCLES = 400;  // long consumer hold-off, to back the block up
  localparam int TAIL_CYCLES = 10;   // slack for the last verdict to pass the input and result registers

  typedef logic [7:0] byte_q_t[$];

  // One byte request as offered to the block; burst requests skip sender gaps.
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         burst;
  } byte_req_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] count;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        buffer_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  verdict_o;
  logic [15:0] consume_count_o;

  dnp3_link_frame_checker_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .buffer_last_i,
    .out_valid_o,
    .out_stall_i,
    .verdict_o,
    .consume_count_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and scoreboard storage
  byte_req_t pending_bytes[$];
  verdict_t  expected_verdicts[$];

  int fails = 0;
  int bytes_in = 0;        // requests accepted by the block
  int passes_built = 0;
  int short_reqs = 0;      // requests subject to random sender gaps
  int burst_reqs = 0;
  int verdict_seen[5];
  longint unsigned cycles = 0;
  longint unsigned cycle_limit = 64'd50_000_000;

  logic in_taken = 1'b0;   // the request on the pins was accepted at the last rising edge
  logic calm;              // stretches where neither side starts a random idle
  assign calm = ((bytes_in / 200) % 4) == 3;

  // ---------------------------------------------------------------------------
  // Frame scanner model: its own copy of the pass state, advanced per byte.
  // ---------------------------------------------------------------------------
  phase_e                scan_ph;
  logic [COUNT_BITS-1:0] pos;
  logic                  sync_low_seen;
  logic [15:0]           crc_acc;
  logic [8:0]            frame_len;   // length byte in the header, frame total in the body
  logic [4:0]            blk_left;
  logic [8:0]            blk_start;
  logic [8:0]            bad_off;
  logic                  bad_seen;
  logic                  decided;
  verdict_e              pred_verdict;
  logic [15:0]           pred_count;

  // Reflected CRC-16 (poly A6BC), one byte, no final complement.
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic void clear_pass();
    scan_ph       = PhHunt;
    pos           = '0;
    sync_low_seen = 1'b0;
    crc_acc       = '0;
    frame_len     = '0;
    blk_left      = '0;
    blk_start     = '0;
    bad_off       = '0;
    bad_seen      = 1'b0;
    decided       = 1'b0;
  endfunction

  function automatic void start_block(int unsigned start);
    int unsigned rem, n;
    rem = (frame_len >= start) ? frame_len - start : 0;
    if (rem >= 18) n = 16;
    else if (rem >= 2) n = rem - 2;
    else n = 0;
    blk_start = start[8:0];
    blk_left  = 5'(n + 2);
    crc_acc   = '0;
  endfunction

  // Records a verdict; a verdict on the marked byte also closes the pass.
  function automatic bit settle(verdict_e v, longint unsigned c, logic last);
    pred_verdict = v;
    pred_count   = (c > 64'hFFFF) ? 16'hFFFF : c[15:0];
    if (last) begin
      clear_pass();
    end else begin
      scan_ph = PhDone;
      decided = 1'b1;
    end
    return 1'b1;
  endfunction

  // Advances the scan by one byte; returns 1 when the byte yields a verdict.
  function automatic bit scan_byte(logic [7:0] b, logic last);
    longint unsigned p, cnt;
    int unsigned     len, user, tot;
    logic [7:0]      want;
    p = pos;
    if (decided || scan_ph == PhDone) begin
      // bytes after a decision are dropped until the marked one
      if (last) clear_pass();
      return 1'b0;
    end
    pos = (p < POS_MAX) ? COUNT_BITS'(p + 1) : COUNT_BITS'(POS_MAX);

    case (scan_ph)
      PhHunt: begin
        if (sync_low_seen && b == SYNC_HIGH) begin
          if (p != 1) return settle(VerdictUnframed, p - 1, last);
          scan_ph       = PhHeader;
          sync_low_seen = 1'b0;
          crc_acc       = crc_step(crc_step(16'h0000, SYNC_LOW), SYNC_HIGH);
        end else begin
          sync_low_seen = (b == SYNC_LOW);
          if (last) begin
            // a trailing 05 may be the start of a sync, so it stays
            cnt = longint'(pos) - ((b == SYNC_LOW) ? 1 : 0);
            return settle((cnt != 0) ? VerdictUnframed : VerdictNeedMore, cnt, 1'b1);
          end
        end
      end
      PhHeader: begin
        if (p == 2) frame_len = 9'(b);
        if (p < 8) begin
          crc_acc = crc_step(crc_acc, b);
          if (p == 7) crc_acc = ~crc_acc;
        end else if (p == 8) begin
          if (b != crc_acc[7:0]) bad_seen = 1'b1;
        end else begin
          if (b != crc_acc[15:8]) bad_seen = 1'b1;
          len = frame_len;
          if (bad_seen || len < 5) return settle(VerdictFalseStart, 2, last);
          user = len - 5;
          tot  = len + 5 + 2 * (user / 16) + (((user % 16) != 0) ? 2 : 0);
          if (tot == 10) return settle(VerdictGood, 10, last);
          frame_len = 9'(tot);
          bad_seen  = 1'b0;
          bad_off   = '0;
          scan_ph   = PhBody;
          start_block(10);
        end
      end
      default: begin
        if (blk_left > 2) begin
          crc_acc = crc_step(crc_acc, b);
          if (blk_left == 3) crc_acc = ~crc_acc;
        end else begin
          want = (blk_left == 2) ? crc_acc[7:0] : crc_acc[15:8];
          if (b != want && !bad_seen) begin
            bad_seen = 1'b1;
            bad_off  = blk_start;
          end
        end
        if (blk_left > 0) blk_left = blk_left - 5'd1;
        if (p + 1 >= frame_len) begin
          if (bad_seen) return settle(VerdictCorrupt, bad_off, last);
          return settle(VerdictGood, frame_len, last);
        end
        if (blk_left == 0) start_block(int'(p + 1));
      end
    endcase

    if (last) return settle(VerdictNeedMore, 0, 1'b1);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly short idles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, MAX_GAP);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(5, 40);
    if (r < 95) return $urandom_range(41, 120);
    return $urandom_range(121, 255);
  endfunction

  function automatic logic [15:0] block_crc(byte_q_t f, int from, int n);
    logic [15:0] c;
    c = 16'h0000;
    for (int i = 0; i < n; i++) c = crc_step(c, f[from + i]);
    return ~c;
  endfunction

  function automatic byte_q_t junk_bytes(int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Well-formed link frame: header with its CRC, then data blocks of up to 16 bytes, each with a CRC.
  function automatic byte_q_t build_frame(int unsigned len);
    byte_q_t     f;
    logic [15:0] c;
    int unsigned left, n, start;
    f = {SYNC_LOW, SYNC_HIGH, 8'(len)};
    repeat (5) f.push_back(8'($urandom_range(0, 255)));
    c = block_crc(f, 0, 8);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    left = (len > 5) ? len - 5 : 0;
    while (left > 0) begin
      n = (left > 16) ? 16 : left;
      start = f.size();
      repeat (n) f.push_back(8'($urandom_range(0, 255)));
      c = block_crc(f, start, n);
      f.push_back(c[7:0]);
      f.push_back(c[15:8]);
      left -= n;
    end
    return f;
  endfunction

  // Queues one buffer pass; its final byte carries the last-byte marker.
  task automatic add_pass(byte_q_t q, bit burst);
    for (int i = 0; i < q.size(); i++) begin
      pending_bytes.push_back('{data: q[i], last: (i == q.size() - 1), burst: burst});
    end
    if (burst) burst_reqs += q.size();
    else short_reqs += q.size();
    passes_built++;
  endtask

  task automatic flip_bit(ref byte_q_t q, input int lo);
    int idx;
    idx = $urandom_range(lo, q.size() - 1);
    q[idx] = q[idx] ^ 8'(1 << $urandom_range(0, 7));
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one request at a time from the pending queue, changed at the falling edge
  // ---------------------------------------------------------------------------
  int gap_left = 0;

  always @(negedge clk_i) begin : sender
    byte_req_t req;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        req = pending_bytes.pop_front();
        data_byte_i   <= req.data;
        buffer_last_i <= req.last;
        in_valid_i    <= 1'b1;
        gap_left      <= (req.burst || calm) ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus two long hold-offs while the sender keeps going
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;
  int holds_done = 0;

  always @(negedge clk_i) begin : receiver
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_done < 2 && bytes_in >= 300 + 600 * holds_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      holds_done  <= holds_done + 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted byte, checks each accepted verdict
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    verdict_t exp_v;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        bytes_in++;
        if (scan_byte(data_byte_i, buffer_last_i)) begin
          expected_verdicts.push_back('{verdict: pred_verdict, count: pred_count});
        end
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: verdict %0d consume_count %0d", verdict_o,
                 consume_count_o);
          fails++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (verdict_o !== exp_v.verdict) begin
            $error("verdict: expected %0d, got %0d", exp_v.verdict, verdict_o);
            fails++;
          end
          if (consume_count_o !== exp_v.count) begin
            $error("consume_count: expected %0d, got %0d", exp_v.count, consume_count_o);
            fails++;
          end
          verdict_seen[exp_v.verdict]++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > cycle_limit) begin
      $display("Timed out after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed passes, then random passes
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    byte_q_t frm;
    int      kind, len;
    bit      first;

    clear_pass();
    foreach (verdict_seen[i]) verdict_seen[i] = 0;

    // Lone 05: nothing to discard yet
    frm = {SYNC_LOW};
    add_pass(frm, 1'b0);
    // Junk ahead of the sync, verdict on the 64 byte
    frm = {8'h00, 8'hFF, SYNC_LOW, SYNC_HIGH};
    add_pass(frm, 1'b0);
    // Sync only: the header is still to come
    frm = {SYNC_LOW, SYNC_HIGH};
    add_pass(frm, 1'b0);
    // Header-only frame
    add_pass(build_frame(5), 1'b0);
    // Length byte too short, CRC intact
    add_pass(build_frame(0), 1'b0);
    // One data byte with a damaged block CRC
    frm = build_frame(6);
    frm[11] = frm[11] ^ 8'h01;
    add_pass(frm, 1'b0);

    first = 1'b1;
    while (short_reqs < 1350 || passes_built < 60) begin
      kind = $urandom_range(0, 99);
      len  = first ? 255 : pick_len();
      first = 1'b0;
      frm = build_frame(len);
      if (kind < 45) begin
        // clean frame, sometimes with more buffer behind it
        if ($urandom_range(0, 2) == 0) frm = {frm, junk_bytes($urandom_range(1, 5))};
      end else if (kind < 55) begin
        // damage in a data block or its CRC
        if (len == 5) frm = build_frame($urandom_range(6, 60));
        flip_bit(frm, 10);
      end else if (kind < 63) begin
        // damage in the header
        frm[$urandom_range(2, 9)] = frm[$urandom_range(2, 9)] ^ 8'(1 << $urandom_range(0, 7));
      end else if (kind < 68) begin
        frm = build_frame($urandom_range(0, 4));
      end else if (kind < 78) begin
        // buffer ends part way through the frame
        if (frm.size() > 11 && $urandom_range(0, 1) == 1) flip_bit(frm, 10);
        frm = frm[0:$urandom_range(1, frm.size() - 1) - 1];
      end else if (kind < 88) begin
        frm = {junk_bytes($urandom_range(1, 6)), frm};
      end else if (kind < 96) begin
        frm = junk_bytes($urandom_range(1, 8));
        if ($urandom_range(0, 1) == 1) frm[$] = SYNC_LOW;
      end else begin
        frm = junk_bytes($urandom_range(1, 30));
      end
      add_pass(frm, 1'b0);
    end

    // Worst case: every request waits out the longest gap and the longest stall
    cycle_limit = 4 * (longint'(short_reqs) * (2 * MAX_GAP + 8) + longint'(burst_reqs) * 2
                       + 2 * HOLD_CYCLES) + 20000;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", expected_verdicts.size());
      fails++;
    end

    $display("Ran %0d passes, %0d bytes, with %0d long receiver hold-offs",
             passes_built, bytes_in, holds_done);
    $display("Verdicts checked: need more %0d, unframed %0d, false start %0d, good %0d, corrupt %0d",
             verdict_seen[VerdictNeedMore], verdict_seen[VerdictUnframed],
             verdict_seen[VerdictFalseStart], verdict_seen[VerdictGood],
             verdict_seen[VerdictCorrupt]);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
